FILE: sv/particle_euler_step_collide_defines.svh
// assertion macros shared by the particle step files
`ifndef PARTICLE_EULER_STEP_COLLIDE_DEFINES_SVH
`define PARTICLE_EULER_STEP_COLLIDE_DEFINES_SVH

// concurrent check on the block clock, off while reset is asserted
`define PES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define PES_NEVER(lbl, cond, msg) \
	`PES_ASSERT(lbl, !(cond), msg)

`endif

FILE: sv/pes_pkg.sv
// shared types, constants and helpers of the particle step block
package pes_pkg;

	localparam int unsigned NUM_AXES    = 3;
	localparam int unsigned SQRT_STAGES = 32;
	localparam int unsigned DIV_STAGES  = 31;
	localparam int unsigned DIV_CYCLES  = 48;

	localparam logic [30:0] MASS_RST   = 31'd6554;
	localparam logic [30:0] TSTEP_RST  = 31'd655;
	localparam logic [30:0] RADIUS_RST = 31'd65536;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_FORCE_X = 3'd0,
		REG_FORCE_Y = 3'd1,
		REG_FORCE_Z = 3'd2,
		REG_MASS    = 3'd3,
		REG_TSTEP   = 3'd4,
		REG_RADIUS  = 3'd5,
		REG_FLOOR   = 3'd6
	} reg_idx_t;

	typedef logic [NUM_AXES-1:0][31:0] vec3_t;

	typedef struct packed {
		vec3_t pos;
		vec3_t vel;
		logic  in_sphere;
		logic  zero;
	} item_t;

	function automatic logic [47:0] sext48(input logic [31:0] v);
		return {{16{v[31]}}, v};
	endfunction

	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return S32_MAX;
		end else if (v < -48'sd2147483648) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

FILE: sv/pes_accel.sv
// bit-serial divider that turns the force registers into per-axis acceleration
`include "particle_euler_step_collide_defines.svh"

module pes_accel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pes_pkg::vec3_t      force_v,
	input  logic [30:0]         mass,
	output pes_pkg::vec3_t      accel,
	output logic                busy
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	localparam logic [5:0] LAST_CNT  = 6'(pes_pkg::DIV_CYCLES - 1);
	localparam logic [1:0] LAST_AXIS = 2'(pes_pkg::NUM_AXES - 1);

	state_t         state_q;
	logic [1:0]     axis_q;
	logic [5:0]     cnt_q;
	logic [47:0]    dvd_q;
	logic [31:0]    rem_q;
	logic [47:0]    quo_q;
	logic           neg_q;
	logic           fzero_q;
	pes_pkg::vec3_t accel_q;

	logic [31:0] rem_sh, rem_nx;
	logic [47:0] quo_nx;
	logic        ge;
	logic [31:0] res;
	logic [31:0] fnext;

	always_comb begin
		rem_sh = {rem_q[30:0], dvd_q[47]};
		ge     = rem_sh >= {1'b0, mass};
		rem_nx = ge ? (rem_sh - {1'b0, mass}) : rem_sh;
		quo_nx = {quo_q[46:0], ge};
		if (mass == 31'd0) begin
			// division by zero gives the signed extreme, or zero for a zero force
			res = fzero_q ? 32'd0 : (neg_q ? pes_pkg::S32_MIN : pes_pkg::S32_MAX);
		end else if (!neg_q) begin
			res = (quo_nx > 48'd2147483647) ? pes_pkg::S32_MAX : quo_nx[31:0];
		end else begin
			res = (quo_nx > 48'd2147483648) ? pes_pkg::S32_MIN : (~quo_nx[31:0] + 32'd1);
		end
		fnext = force_v[axis_q + 2'd1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 2'd0;
			cnt_q   <= 6'd0;
			accel_q <= '0;
		end else if (start) begin
			state_q <= ST_RUN;
			axis_q  <= 2'd0;
			cnt_q   <= 6'd0;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == LAST_CNT) begin
				accel_q[axis_q] <= res;
				cnt_q           <= 6'd0;
				if (axis_q == LAST_AXIS) begin
					state_q <= ST_IDLE;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
		end
	end

	// datapath, reloaded at the start of every axis
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= {pes_pkg::mag32(force_v[0]), 16'd0};
			neg_q   <= force_v[0][31];
			fzero_q <= force_v[0] == 32'd0;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (state_q == ST_RUN) begin
			if (cnt_q == LAST_CNT) begin
				dvd_q   <= {pes_pkg::mag32(fnext), 16'd0};
				neg_q   <= fnext[31];
				fzero_q <= fnext == 32'd0;
				rem_q   <= '0;
				quo_q   <= '0;
			end else begin
				dvd_q <= {dvd_q[46:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
		end
	end

	assign accel = accel_q;
	assign busy  = state_q == ST_RUN;

	`PES_ASSERT(a_done_last_axis, $fell(busy) |-> ($past(axis_q) == LAST_AXIS) && ($past(cnt_q) == LAST_CNT), "accel unit finished early")

endmodule

FILE: sv/particle_euler_step_collide.sv
// top level of the particle Euler step with sphere and floor collision
//
// One particle item enters per cycle unless the input is stalled. Its path is:
// five stages of velocity, position and squared-length arithmetic, a 32-stage
// square root (one result bit per stage), one stage forming |c| * radius and a
// 31-stage divider (one quotient bit per stage, three lanes), then the output
// register. A stalled output freezes the whole pipeline. A write to a force
// register or the mass restarts the acceleration divider in the following cycle,
// which then works through the three axes in turn; the input is stalled from
// the restart until the divider is done.
`include "particle_euler_step_collide_defines.svh"

module particle_euler_step_collide (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_pos_z,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	output logic [31:0] new_vel_z
);

	localparam int unsigned NSQ = pes_pkg::SQRT_STAGES;
	localparam int unsigned NDV = pes_pkg::DIV_STAGES;

	// configuration
	pes_pkg::vec3_t    force_q;
	logic [30:0]       mass_q, tstep_q, radius_q;
	logic [31:0]       floor_q;
	logic [63:0]       rsq_q;
	pes_pkg::reg_idx_t idx;
	logic              wr, accel_start, accel_busy, accel_go_q;
	pes_pkg::vec3_t    accel;

	assign idx    = pes_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q  <= '0;
			mass_q   <= pes_pkg::MASS_RST;
			tstep_q  <= pes_pkg::TSTEP_RST;
			radius_q <= pes_pkg::RADIUS_RST;
			floor_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				pes_pkg::REG_FORCE_X: force_q[0] <= pwdata;
				pes_pkg::REG_FORCE_Y: force_q[1] <= pwdata;
				pes_pkg::REG_FORCE_Z: force_q[2] <= pwdata;
				pes_pkg::REG_MASS:    mass_q     <= pwdata[30:0];
				pes_pkg::REG_TSTEP:   tstep_q    <= pwdata[30:0];
				pes_pkg::REG_RADIUS:  radius_q   <= pwdata[30:0];
				pes_pkg::REG_FLOOR:   floor_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pes_pkg::REG_FORCE_X: prdata = force_q[0];
			pes_pkg::REG_FORCE_Y: prdata = force_q[1];
			pes_pkg::REG_FORCE_Z: prdata = force_q[2];
			pes_pkg::REG_MASS:    prdata = {1'b0, mass_q};
			pes_pkg::REG_TSTEP:   prdata = {1'b0, tstep_q};
			pes_pkg::REG_RADIUS:  prdata = {1'b0, radius_q};
			pes_pkg::REG_FLOOR:   prdata = floor_q;
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		rsq_q <= 64'(radius_q) * 64'(radius_q);
	end

	assign accel_start = wr && (idx == pes_pkg::REG_FORCE_X || idx == pes_pkg::REG_FORCE_Y ||
		idx == pes_pkg::REG_FORCE_Z || idx == pes_pkg::REG_MASS);

	// start once the written value has landed in the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_go_q <= 1'b0;
		end else begin
			accel_go_q <= accel_start;
		end
	end

	pes_accel u_accel (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accel_go_q),
		.force_v (force_q),
		.mass    (mass_q),
		.accel   (accel),
		.busy    (accel_busy)
	);

	// pipeline control
	logic pipe_en, accept, out_valid_q;
	assign pipe_en  = !(out_valid_q && out_stall);
	assign in_stall = accel_go_q || accel_busy || !pipe_en;
	assign accept   = in_valid && !in_stall;

	pes_pkg::vec3_t pin, vin;
	assign pin = {pos_z, pos_y, pos_x};
	assign vin = {vel_z, vel_y, vel_x};

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	pes_pkg::vec3_t pos_s1, vel_s1, pos_s2, vel_s2, pos_s3, vel_s3, pos_s4, vel_s4;
	logic [2:0][63:0] prod_s2, sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] sh;
		if (pipe_en) begin
			for (int i = 0; i < pes_pkg::NUM_AXES; i++) begin
				pos_s1[i] <= pin[i];
				vel_s1[i] <= pes_pkg::sat32(pes_pkg::sext48(vin[i]) +
					pes_pkg::sext48(accel[i]));
				prod_s2[i] <= $signed({{32{vel_s1[i][31]}}, vel_s1[i]}) *
					$signed({33'd0, tstep_q});
				// step is rounded towards minus infinity
				sh = $signed(prod_s2[i]) >>> 16;
				pos_s3[i] <= pes_pkg::sat32(pes_pkg::sext48(pos_s2[i]) + sh[47:0]);
				sq_s4[i] <= 64'(pes_pkg::mag32(pos_s3[i])) * 64'(pes_pkg::mag32(pos_s3[i]));
			end
			pos_s2 <= pos_s1;
			vel_s2 <= vel_s1;
			vel_s3 <= vel_s2;
			pos_s4 <= pos_s3;
			vel_s4 <= vel_s3;
		end
	end

	// square root: stage 0 holds the squared length
	logic [63:0]    rem_sqrt_s [NSQ+1];
	logic [63:0]    res_sqrt_s [NSQ+1];
	pes_pkg::item_t it_sqrt_s  [NSQ+1];
	logic           vld_sqrt_s [NSQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sqrt_s[0] <= 1'b0;
		end else if (pipe_en) begin
			vld_sqrt_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] sum;
		if (pipe_en) begin
			sum = sq_s4[0] + sq_s4[1] + sq_s4[2];
			rem_sqrt_s[0]          <= sum;
			res_sqrt_s[0]          <= '0;
			it_sqrt_s[0].pos       <= pos_s4;
			it_sqrt_s[0].vel       <= vel_s4;
			it_sqrt_s[0].in_sphere <= sum < rsq_q;
			it_sqrt_s[0].zero      <= sum == 64'd0;
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [63:0] bit_k, trial;
		logic        take;
		assign bit_k = 64'd1 << (2 * (NSQ - 1 - k));
		assign trial = res_sqrt_s[k] + bit_k;
		assign take  = rem_sqrt_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sqrt_s[k+1] <= 1'b0;
			end else if (pipe_en) begin
				vld_sqrt_s[k+1] <= vld_sqrt_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rem_sqrt_s[k+1] <= take ? (rem_sqrt_s[k] - trial) : rem_sqrt_s[k];
				res_sqrt_s[k+1] <= take ? ((res_sqrt_s[k] >> 1) + bit_k) : (res_sqrt_s[k] >> 1);
				it_sqrt_s[k+1]  <= it_sqrt_s[k];
			end
		end
	end

	// divider: stage 0 holds |c| * radius and the length
	logic [2:0][62:0] rem_div_s [NDV+1];
	logic [2:0][30:0] q_div_s   [NDV+1];
	logic [31:0]      len_div_s [NDV+1];
	pes_pkg::item_t   it_div_s  [NDV+1];
	logic             vld_div_s [NDV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_div_s[0] <= 1'b0;
		end else if (pipe_en) begin
			vld_div_s[0] <= vld_sqrt_s[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < pes_pkg::NUM_AXES; i++) begin
				rem_div_s[0][i] <= 63'(pes_pkg::mag32(it_sqrt_s[NSQ].pos[i])) * 63'(radius_q);
			end
			q_div_s[0]   <= '0;
			len_div_s[0] <= res_sqrt_s[NSQ][31:0];
			it_div_s[0]  <= it_sqrt_s[NSQ];
		end
	end

	for (genvar j = 0; j < NDV; j++) begin : g_div
		logic [62:0] dvs;
		assign dvs = 63'(len_div_s[j]) << (NDV - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_div_s[j+1] <= 1'b0;
			end else if (pipe_en) begin
				vld_div_s[j+1] <= vld_div_s[j];
			end
		end

		always_ff @(posedge clk) begin
			logic take;
			if (pipe_en) begin
				for (int i = 0; i < pes_pkg::NUM_AXES; i++) begin
					take = rem_div_s[j][i] >= dvs;
					rem_div_s[j+1][i] <= take ? (rem_div_s[j][i] - dvs) : rem_div_s[j][i];
					q_div_s[j+1][i]   <= {q_div_s[j][i][29:0], take};
				end
				len_div_s[j+1] <= len_div_s[j];
				it_div_s[j+1]  <= it_div_s[j];
			end
		end
	end

	// push out of the sphere, then the floor clamp
	pes_pkg::item_t fin;
	pes_pkg::vec3_t pos_fin;
	assign fin = it_div_s[NDV];

	always_comb begin
		pos_fin = fin.pos;
		if (fin.in_sphere) begin
			if (fin.zero) begin
				pos_fin = {32'd0, {1'b0, radius_q}, 32'd0};
			end else begin
				for (int i = 0; i < pes_pkg::NUM_AXES; i++) begin
					pos_fin[i] = fin.pos[i][31] ? (~{1'b0, q_div_s[NDV][i]} + 32'd1) :
						{1'b0, q_div_s[NDV][i]};
				end
			end
		end
		if ($signed(pos_fin[1]) < $signed(floor_q)) begin
			pos_fin[1] = floor_q;
		end
	end

	pes_pkg::vec3_t npos_q, nvel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= vld_div_s[NDV];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			npos_q <= pos_fin;
			nvel_q <= fin.vel;
		end
	end

	assign out_valid = out_valid_q;
	assign new_pos_x = npos_q[0];
	assign new_pos_y = npos_q[1];
	assign new_pos_z = npos_q[2];
	assign new_vel_x = nvel_q[0];
	assign new_vel_y = nvel_q[1];
	assign new_vel_z = nvel_q[2];

	`PES_ASSERT(a_freeze_holds, !pipe_en |=> $stable(vld_s1) && $stable(vld_sqrt_s[NSQ]) && $stable(vld_div_s[NDV]), "pipeline moved while frozen")
	`PES_NEVER(a_quot_bound, vld_div_s[NDV] && fin.in_sphere && !fin.zero && (q_div_s[NDV][0] > radius_q || q_div_s[NDV][1] > radius_q || q_div_s[NDV][2] > radius_q), "push-out coordinate exceeds radius")

endmodule

FILE: bench/tb_particle_euler_step_collide.sv
// self-checking bench for the particle euler step with sphere and floor collision
`timescale 1ns / 100ps

module tb_particle_euler_step_collide;

	typedef struct packed {
		logic [31:0] px, py, pz, vx, vy, vz;
	} particle_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall, out_valid, out_stall;
	particle_t   drv_item, got;

	particle_t   pending_q[$];
	particle_t   expected_q[$];
	int          mismatches;
	bit          calm;
	int          in_gap, out_gap;

	// shadow copy of the register file
	longint      frc[3];
	longint      mass, tstep, radius, floor_y;

	particle_euler_step_collide dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(drv_item.px), .pos_y(drv_item.py), .pos_z(drv_item.pz),
		.vel_x(drv_item.vx), .vel_y(drv_item.vy), .vel_z(drv_item.vz),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_pos_x(got.px), .new_pos_y(got.py), .new_pos_z(got.pz),
		.new_vel_x(got.vx), .new_vel_y(got.vy), .new_vel_z(got.vz)
	);

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned res, trial;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = res | (64'd1 << b);
			if (trial * trial <= s) res = trial;
		end
		return res;
	endfunction

	function automatic longint unsigned square_mag(longint c);
		longint unsigned m;
		m = (c < 0) ? -c : c;
		return m * m;
	endfunction

	// one euler step, then sphere push-out and floor clamp
	function automatic particle_t advance_particle(particle_t a);
		longint p[3], v[3], acc, len;
		longint unsigned s;
		particle_t r;
		p[0] = $signed(a.px); p[1] = $signed(a.py); p[2] = $signed(a.pz);
		v[0] = $signed(a.vx); v[1] = $signed(a.vy); v[2] = $signed(a.vz);
		for (int i = 0; i < 3; i++) begin
			if (mass == 0) acc = (frc[i] > 0) ? 64'sd2147483647 :
				(frc[i] < 0) ? -64'sd2147483648 : 0;
			else acc = clamp32((frc[i] * 65536) / mass);
			v[i] = clamp32(v[i] + acc);
			p[i] = clamp32(p[i] + ((v[i] * tstep) >>> 16));
		end
		s = square_mag(p[0]) + square_mag(p[1]) + square_mag(p[2]);
		if (s < longint'(radius) * longint'(radius)) begin
			if (s == 0) begin
				p[0] = 0; p[1] = radius; p[2] = 0;
			end else begin
				len = root_floor(s);
				for (int i = 0; i < 3; i++) p[i] = (p[i] * radius) / len;
			end
		end
		if (p[1] < floor_y) p[1] = floor_y;
		r.px = p[0][31:0]; r.py = p[1][31:0]; r.pz = p[2][31:0];
		r.vx = v[0][31:0]; r.vy = v[1][31:0]; r.vz = v[2][31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 65) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] edge_val();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'd1;
			4: return 32'h0001_0000;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [31:0] near_val(longint span);
		longint v;
		if (span > 64'sd2147483647) span = 64'sd2147483647;
		v = longint'($urandom_range(0, 32'(2 * span))) - span;
		return 32'(clamp32(v));
	endfunction

	function automatic particle_t rand_particle();
		particle_t a;
		longint sp;
		int k;
		k = $urandom_range(0, 99);
		sp = 2 * radius + 65536;
		if (k < 55) begin
			a.px = near_val(sp); a.py = near_val(sp); a.pz = near_val(sp);
			a.vx = near_val(1 << 18); a.vy = near_val(1 << 18); a.vz = near_val(1 << 18);
		end else if (k < 80) begin
			a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			a = {edge_val(), edge_val(), edge_val(), edge_val(), edge_val(), edge_val()};
		end
		return a;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_item <= '0;
			in_gap   <= 0;
		end else begin
			if (in_valid && !in_stall) expected_q.push_back(advance_particle(drv_item));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (pending_q.size() > 0) begin
					drv_item <= pending_q.pop_front();
					in_valid <= 1'b1;
					in_gap   <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and output back-pressure
	always @(posedge clk or negedge arst_n) begin
		particle_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected item %h", got);
				end else begin
					e = expected_q.pop_front();
					if (e !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch pos %h %h %h vel %h %h %h / got %h %h %h %h %h %h",
								e.px, e.py, e.pz, e.vx, e.vy, e.vz,
								got.px, got.py, got.pz, got.vx, got.vy, got.vz);
					end
				end
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap   <= out_gap - 1;
			end else begin
				out_stall <= 1'b0;
				out_gap   <= pick_gap();
			end
		end
	end

	task automatic reg_write(pes_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			pes_pkg::REG_FORCE_X: frc[0] = $signed(val);
			pes_pkg::REG_FORCE_Y: frc[1] = $signed(val);
			pes_pkg::REG_FORCE_Z: frc[2] = $signed(val);
			pes_pkg::REG_MASS:    mass    = val[30:0];
			pes_pkg::REG_TSTEP:   tstep   = val[30:0];
			pes_pkg::REG_RADIUS:  radius  = val[30:0];
			pes_pkg::REG_FLOOR:   floor_y = $signed(val);
			default: ;
		endcase
	endtask

	// wait for every result, then let the pipeline drain
	task automatic drain();
		while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
		logic [31:0] m, logic [31:0] ts, logic [31:0] rad, logic [31:0] fl);
		drain();
		reg_write(pes_pkg::REG_FORCE_X, fx);
		reg_write(pes_pkg::REG_FORCE_Y, fy);
		reg_write(pes_pkg::REG_FORCE_Z, fz);
		reg_write(pes_pkg::REG_MASS, m);
		reg_write(pes_pkg::REG_TSTEP, ts);
		reg_write(pes_pkg::REG_RADIUS, rad);
		reg_write(pes_pkg::REG_FLOOR, fl);
		calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_q.push_back(rand_particle());
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		mismatches = 0;
		calm = 1'b0;
		frc[0] = 0; frc[1] = 0; frc[2] = 0;
		mass = pes_pkg::MASS_RST; tstep = pes_pkg::TSTEP_RST;
		radius = pes_pkg::RADIUS_RST; floor_y = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: origin, inside, floor clamp, saturating sums
		pending_q.push_back('0);
		pending_q.push_back({32'd100, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		pending_q.push_back({32'h0000_8000, 32'h0000_4000, 32'hffff_c000, 96'd0});
		pending_q.push_back({32'h0001_0000, 32'd0, 32'd0, 96'd0});
		pending_q.push_back({32'h0000_ffff, 32'd0, 32'd0, 96'd0});
		pending_q.push_back({32'h0005_0000, 32'hfffb_0000, 32'd0, 96'd0});
		pending_q.push_back({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
		pending_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		pending_q.push_back({32'd0, 32'hffff_ffff, 32'd0, 32'd0, 32'hffff_ffff, 32'd0});
		pending_q.push_back({32'h0002_0000, 32'h0002_0000, 32'd0,
			32'hfff0_0000, 32'hfff0_0000, 32'd0});
		queue_random(240);

		set_all(32'h0000_8000, 32'hfff6_0000, 32'h0000_1234, 32'h0001_0000,
			32'h0001_0000, 32'h0003_0000, 32'hfffe_0000);
		pending_q.push_back('0);
		queue_random(340);

		// extremes, zero mass
		set_all(32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		pending_q.push_back('0);
		pending_q.push_back({32'h7fff_ffff, 32'h8000_0000, 32'd0, 96'd0});
		queue_random(250);

		// zero radius, highest floor
		set_all($urandom, $urandom, $urandom, 32'd1, 32'd1, 32'd0, 32'h7fff_ffff);
		pending_q.push_back('0);
		queue_random(250);

		repeat (3) begin
			set_all($urandom, $urandom, $urandom,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000),
				$urandom_range(0, 32'h0002_0000),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000),
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0002_0000));
			queue_random(250);
		end

		drain();
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
